### hdl/spq_pkg.sv
// Package for the sorted priority queue: entry and control types, op and status codes.
// No dependencies. Imported by spq_cell, sorted_priority_queue, spq_checker and sorted_priority_queue_tb.
package spq_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int TAG_W        = 16;
	localparam int PRIO_W       = 32;
	localparam int OCC_W        = 5;

	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_DEQUEUE = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_EMPTY_ERROR  = 2'd1;
	localparam logic [1:0] ST_FULL_DROPPED = 2'd2;

	typedef logic [TAG_W-1:0]         tag_t;
	typedef logic signed [PRIO_W-1:0] prio_t;

	// One slot of the queue.
	typedef struct packed {
		logic  valid;
		tag_t  tag;
		prio_t prio;
	} entry_t;

	// Broadcast to every cell for the request being taken this cycle.
	typedef struct packed {
		logic  enq;
		logic  deq;
		logic  clr;
		tag_t  tag;
		prio_t prio;
	} ctl_t;

endpackage

### hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts right on insert, left on removal.
// Depends on spq_pkg.
module spq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  spq_pkg::ctl_t  ctl,
	input  spq_pkg::entry_t left_entry,
	input  logic           left_behind,
	input  spq_pkg::entry_t right_entry,
	output spq_pkg::entry_t entry,
	output logic           behind,
	output spq_pkg::entry_t next_entry
);
	import spq_pkg::*;

	logic  valid_q;
	tag_t  tag_q;
	prio_t prio_q;

	assign entry = '{valid: valid_q, tag: tag_q, prio: prio_q};

	// New entry goes behind this one when this slot's priority is equal or lower.
	assign behind = valid_q && !(ctl.prio < prio_q);

	always_comb begin
		next_entry = entry;
		if (ctl.clr) begin
			next_entry.valid = 1'b0;
		end else if (ctl.enq) begin
			if (!behind) begin
				if (left_behind) begin
					next_entry = '{valid: 1'b1, tag: ctl.tag, prio: ctl.prio};
				end else begin
					next_entry = left_entry;
				end
			end
		end else if (ctl.deq) begin
			next_entry = right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= next_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_q  <= next_entry.tag;
		prio_q <= next_entry.prio;
	end

	// Valid slots form a prefix and stay in ascending priority order.
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> !right_entry.valid)
		else $error("spq_cell: occupied slot behind an empty one");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && right_entry.valid) |-> !(right_entry.prio < prio_q))
		else $error("spq_cell: chain out of priority order");

endmodule

### hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell slots plus a result register.
// Depends on spq_pkg and spq_cell.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    op, value_tag, priority_req
//   out      source     out_valid / out_ready  out_tag, head_tag, head_priority,
//                                              occupancy, is_empty, status
//
// Rate: one request per cycle while the result is taken; all slots compare against the
//   new priority in parallel and shift together at the same clock edge.
// The result is registered; in_ready is high whenever that register is empty or is
//   being taken in the same cycle, so a stalled result blocks only further requests.
// Reset clears the count and every slot's valid bit at once; no clearing pass.
module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  spq_pkg::tag_t        value_tag,
	input  spq_pkg::prio_t       priority_req,
	output logic                 out_valid,
	input  logic                 out_ready,
	output spq_pkg::tag_t        out_tag,
	output spq_pkg::tag_t        head_tag,
	output spq_pkg::prio_t       head_priority,
	output logic [spq_pkg::OCC_W-1:0] occupancy,
	output logic                 is_empty,
	output logic [1:0]           status
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             in_fire;
	logic             full;
	logic             empty;
	ctl_t             ctl;
	logic [1:0]       status_next;
	logic [CNT_W+OCC_W-1:0] count_ext;

	entry_t cell_entry [CAPACITY];
	entry_t cell_next  [CAPACITY];
	logic   cell_behind[CAPACITY];

	logic             out_valid_q;
	tag_t             out_tag_q;
	tag_t             head_tag_q;
	prio_t            head_prio_q;
	logic [OCC_W-1:0] occ_q;
	logic             empty_q;
	logic [1:0]       status_q;

	// Take a request when the result register is free or draining now.
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign full  = (count_q == CAPACITY[CNT_W-1:0]);
	assign empty = (count_q == '0);

	// Drop enqueues into a full queue; ignore dequeues on an empty one.
	always_comb begin
		ctl.enq  = in_fire && (op == OP_ENQUEUE) && !full;
		ctl.deq  = in_fire && (op == OP_DEQUEUE) && !empty;
		ctl.clr  = in_fire && (op == OP_CLEAR);
		ctl.tag  = value_tag;
		ctl.prio = priority_req;
	end

	always_comb begin
		count_next  = count_q;
		status_next = ST_OK;
		if (ctl.clr) begin
			count_next = '0;
		end else if (ctl.enq) begin
			count_next = count_q + 1'b1;
		end else if (ctl.deq) begin
			count_next = count_q - 1'b1;
		end
		if (op == OP_ENQUEUE && full) begin
			status_next = ST_FULL_DROPPED;
		end else if (op == OP_DEQUEUE && empty) begin
			status_next = ST_EMPTY_ERROR;
		end
	end

	// Occupancy reports the low five bits of the count.
	assign count_ext = {{OCC_W{1'b0}}, count_next};

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			entry_t left_e;
			entry_t right_e;
			logic   left_b;
			if (g == 0) begin : g_first
				assign left_e = '0;
				assign left_b = 1'b1;
			end else begin : g_mid
				assign left_e = cell_entry[g-1];
				assign left_b = cell_behind[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign right_e = '0;
			end else begin : g_inner
				assign right_e = cell_entry[g+1];
			end
			spq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.left_entry  (left_e),
				.left_behind (left_b),
				.right_entry (right_e),
				.entry       (cell_entry[g]),
				.behind      (cell_behind[g]),
				.next_entry  (cell_next[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: the head after the step comes from the first cell's next value.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_tag_q   <= ctl.deq ? cell_entry[0].tag : '0;
			head_tag_q  <= cell_next[0].valid ? cell_next[0].tag : '0;
			head_prio_q <= cell_next[0].valid ? cell_next[0].prio : '0;
			occ_q       <= count_ext[OCC_W-1:0];
			empty_q     <= (count_next == '0);
			status_q    <= status_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_tag       = out_tag_q;
	assign head_tag      = head_tag_q;
	assign head_priority = head_prio_q;
	assign occupancy     = occ_q;
	assign is_empty      = empty_q;
	assign status        = status_q;

	a_count_head: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == !cell_entry[0].valid)
		else $error("sorted_priority_queue: count disagrees with head slot");
	a_count_tail: assert property (@(posedge clk) disable iff (!arst_n)
		full == cell_entry[CAPACITY-1].valid)
		else $error("sorted_priority_queue: count disagrees with last slot");
	a_drop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == OP_ENQUEUE && full) |=> (count_q == $past(count_q)))
		else $error("sorted_priority_queue: dropped enqueue changed the count");
	a_result_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_q) |-> (head_tag_q == '0 && head_prio_q == '0))
		else $error("sorted_priority_queue: empty result shows a head entry");

endmodule

### tb/spq_checker.sv
// Scoreboard for sorted_priority_queue: watches both channels and keeps a sorted-list model.
// Depends on spq_pkg. Instantiated beside the block by sorted_priority_queue_tb.
module spq_checker #(
	parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [1:0]                op,
	input  spq_pkg::tag_t             value_tag,
	input  spq_pkg::prio_t            priority_req,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  spq_pkg::tag_t             out_tag,
	input  spq_pkg::tag_t             head_tag,
	input  spq_pkg::prio_t            head_priority,
	input  logic [spq_pkg::OCC_W-1:0] occupancy,
	input  logic                      is_empty,
	input  logic [1:0]                status,
	output int                        fail_count,
	output int                        pending
);
	import spq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		tag_t             removed_tag;
		tag_t             head_tag;
		prio_t            head_prio;
		logic [OCC_W-1:0] occupancy;
		logic             is_empty;
		logic [1:0]       status;
	} queue_view_t;

	// Entries kept in service order: index 0 is the head.
	tag_t        held_tags [CAPACITY];
	prio_t       held_prios[CAPACITY];
	int          held_count = 0;
	int          mismatches = 0;
	queue_view_t awaited_views[$];

	function automatic queue_view_t apply_request(logic [1:0] code, tag_t tag, prio_t prio);
		queue_view_t view;
		int pos;
		int i;
		view = '0;
		view.status = ST_OK;
		case (code)
			OP_ENQUEUE: begin
				if (held_count >= CAPACITY) begin
					view.status = ST_FULL_DROPPED;
				end else begin
					// go behind every entry of equal or lower priority
					pos = 0;
					while (pos < held_count && prio >= held_prios[pos])
						pos++;
					for (i = held_count; i > pos; i--) begin
						held_tags[i]  = held_tags[i-1];
						held_prios[i] = held_prios[i-1];
					end
					held_tags[pos]  = tag;
					held_prios[pos] = prio;
					held_count++;
				end
			end
			OP_DEQUEUE: begin
				if (held_count == 0) begin
					view.status = ST_EMPTY_ERROR;
				end else begin
					view.removed_tag = held_tags[0];
					for (i = 0; i < held_count - 1; i++) begin
						held_tags[i]  = held_tags[i+1];
						held_prios[i] = held_prios[i+1];
					end
					held_count--;
				end
			end
			OP_CLEAR: begin
				held_count = 0;
			end
			default: begin
			end
		endcase
		if (held_count > 0) begin
			view.head_tag  = held_tags[0];
			view.head_prio = held_prios[0];
		end
		view.occupancy = OCC_W'(held_count);
		view.is_empty  = (held_count == 0);
		return view;
	endfunction

	function automatic void compare_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		queue_view_t want;
		if (!arst_n) begin
			held_count = 0;
		end else begin
			if (in_valid && in_ready)
				awaited_views.push_back(apply_request(op, value_tag, priority_req));
			if (out_valid && out_ready) begin
				if (awaited_views.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = awaited_views.pop_front();
					compare_field("out_tag", want.removed_tag, out_tag);
					compare_field("head_tag", want.head_tag, head_tag);
					compare_field("head_priority", longint'(want.head_prio),
						longint'(head_priority));
					compare_field("occupancy", want.occupancy, occupancy);
					compare_field("is_empty", want.is_empty, is_empty);
					compare_field("status", want.status, status);
				end
			end
		end
		fail_count <= mismatches;
		pending    <= awaited_views.size();
	end

endmodule

### tb/sorted_priority_queue_tb.sv
// Top of the sorted_priority_queue testbench: clock, reset, request stimulus and verdict.
// Depends on spq_pkg, sorted_priority_queue and spq_checker.
module sorted_priority_queue_tb;
	import spq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CAPACITY        = DEF_CAPACITY;
	localparam int         RANDOM_REQUESTS = 800;
	localparam int         CYCLE_LIMIT     = 200_000;
	// op code the block must treat as a no-op
	localparam logic [1:0] OP_UNUSED       = 2'd3;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       op;
	tag_t             value_tag;
	prio_t            priority_req;
	logic             out_valid;
	logic             out_ready;
	tag_t             out_tag;
	tag_t             head_tag;
	prio_t            head_priority;
	logic [OCC_W-1:0] occupancy;
	logic             is_empty;
	logic [1:0]       status;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int burst_left  = 0;
	int ready_style = 0;
	int ready_span  = 0;
	int stall_tick  = 0;

	sorted_priority_queue #(.CAPACITY(CAPACITY)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .value_tag(value_tag), .priority_req(priority_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_tag(out_tag), .head_tag(head_tag), .head_priority(head_priority),
		.occupancy(occupancy), .is_empty(is_empty), .status(status)
	);

	spq_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .value_tag(value_tag), .priority_req(priority_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_tag(out_tag), .head_tag(head_tag), .head_priority(head_priority),
		.occupancy(occupancy), .is_empty(is_empty), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL sorted_priority_queue");
			$finish;
		end
	end

	// Result side: switch between stall styles whenever ready_span runs out, so that
	// back-pressure lands on empty, filling and full queues alike.
	always @(posedge clk) begin
		stall_tick++;
		if (ready_span == 0) begin
			ready_style = $urandom_range(0, 3);
			ready_span  = $urandom_range(16, 96);
		end else begin
			ready_span--;
		end
		case (ready_style)
			0: out_ready <= 1'b1;                          // never stall
			1: out_ready <= ($urandom_range(0, 3) != 0);   // light stalls
			2: out_ready <= ((stall_tick % 6) != 0);       // regular pattern
			default: out_ready <= ($urandom_range(0, 3) == 0); // heavy stalls
		endcase
	end

	// Present one request and hold it until the block takes it.
	task automatic send_request(input logic [1:0] code, input tag_t tag, input prio_t prio);
		in_valid     <= 1'b1;
		op           <= code;
		value_tag    <= tag;
		priority_req <= prio;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Keep valid high inside a burst; drop it for a random gap between bursts.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off new requests until every outstanding result has been taken.
	task automatic drain_queue();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic issue(input logic [1:0] code, input tag_t tag, input prio_t prio);
		send_request(code, tag, prio);
		pace_sender();
	endtask

	// Mix full-range priorities with small sets that force ties and the extremes.
	function automatic prio_t pick_priority();
		case ($urandom_range(0, 4))
			0: return prio_t'($urandom);
			1: return prio_t'((int'($urandom_range(0, 6)) - 3) * 65536);
			2: begin
				case ($urandom_range(0, 3))
					0: return prio_t'(32'h7fff_ffff);
					1: return prio_t'(32'h8000_0000);
					2: return '0;
					default: return '1;
				endcase
			end
			default: return prio_t'($signed($urandom) >>> 12);
		endcase
	endfunction

	initial begin
		int          enq_weight;
		int          roll;
		logic [1:0]  code;

		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		op           <= OP_ENQUEUE;
		value_tag    <= '0;
		priority_req <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-queue corner cases first.
		issue(OP_DEQUEUE, 16'hffff, '1);
		issue(OP_CLEAR, 16'h0000, '0);
		issue(OP_UNUSED, 16'ha5a5, prio_t'(32'h5a5a_5a5a));
		// Extremes of priority and tag, plus equal priorities to check arrival order.
		issue(OP_ENQUEUE, 16'hffff, prio_t'(32'h7fff_ffff));
		issue(OP_ENQUEUE, 16'h0000, prio_t'(32'h8000_0000));
		issue(OP_ENQUEUE, 16'h1234, '0);
		issue(OP_ENQUEUE, 16'h5678, '0);
		issue(OP_ENQUEUE, 16'h9abc, '1);
		issue(OP_UNUSED, 16'h0f0f, prio_t'(32'hf0f0_f0f0));
		// Fill to capacity, then overflow once.
		for (int k = 5; k < CAPACITY; k++)
			issue(OP_ENQUEUE, tag_t'(k), pick_priority());
		issue(OP_ENQUEUE, 16'hdead, '0);
		issue(OP_DEQUEUE, '0, '0);
		issue(OP_DEQUEUE, '0, '0);
		issue(OP_CLEAR, '0, '0);
		issue(OP_DEQUEUE, '0, '0);
		issue(OP_ENQUEUE, 16'h4321, prio_t'(32'h0001_8000));
		drain_queue();

		// Random: phases biased toward filling, draining or balance, so the
		// queue keeps swinging between empty and full.
		enq_weight = 50;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: enq_weight = 85;
					1: enq_weight = 20;
					default: enq_weight = 50;
				endcase
			end
			if (n % 250 == 249)
				drain_queue();
			roll = $urandom_range(0, 99);
			if (roll < 2)
				code = OP_CLEAR;
			else if (roll < 4)
				code = OP_UNUSED;
			else if ($urandom_range(0, 99) < enq_weight)
				code = OP_ENQUEUE;
			else
				code = OP_DEQUEUE;
			issue(code, tag_t'($urandom), pick_priority());
		end

		drain_queue();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS sorted_priority_queue");
		else
			$display("FAIL sorted_priority_queue");
		$finish;
	end

endmodule

### filelist.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
tb/spq_checker.sv
tb/sorted_priority_queue_tb.sv
